[hdl/ipc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants and types of the iteration palette colorizer.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int IPC_PALETTE_DEPTH = 16;
  localparam int IPC_FRACTION_BITS = 16;

  localparam int ITER_W    = 16;
  localparam int SLOT_W    = 4;
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 3 * CHAN_W;
  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;

  typedef enum logic [0:0] {
    OP_COLOR = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITERATIONS = 1'b0,
    CFG_PALETTE_SIZE   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e               op;
    logic              grey;
    logic [SLOT_W-1:0] slot;
    logic [RGB_W-1:0]  rgb;
  } tag_t;

endpackage

[hdl/iteration_palette_colorizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iteration_palette_colorizer
// Escape-count to RGB pixel mapper with a palette store and linear blending.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per item: a
//   colour item (operation_i = 0) yields one pixel beat on the output channel
//   (out_valid_o / out_ready_i); a load item writes one palette slot and
//   yields nothing. Registers max_iterations and palette_size are written
//   over cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   Throughput is one item per cycle while in_ready_o is high. The
//   restoring divider resolves one quotient bit per pipeline stage.
//   Loads travel down the pipe and write the palette at the same stage
//   where colour items read it, so every item sees exactly the loads that
//   came before it.
//   Reset empties the pipe and restores the registers (limit 256, grey
//   scale); palette contents stay undefined until loaded.
//   When the receiver stalls, the pixel holds and earlier stages keep
//   filling their bubbles; in_ready_o drops only once the pipe is full.
// ----------------------------------------------------------------------------
module iteration_palette_colorizer #(
  parameter int PALETTE_DEPTH = ipc_pkg::IPC_PALETTE_DEPTH,
  parameter int FRACTION_BITS = ipc_pkg::IPC_FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ipc_pkg::ITER_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [ipc_pkg::ITER_W-1:0]     iterations_i,
  input  logic [ipc_pkg::SLOT_W-1:0]     entry_index_i,
  input  logic [ipc_pkg::CHAN_W-1:0]     entry_red_i,
  input  logic [ipc_pkg::CHAN_W-1:0]     entry_green_i,
  input  logic [ipc_pkg::CHAN_W-1:0]     entry_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ipc_pkg::CHAN_W-1:0]     pixel_red_o,
  output logic [ipc_pkg::CHAN_W-1:0]     pixel_green_o,
  output logic [ipc_pkg::CHAN_W-1:0]     pixel_blue_o
);
  import ipc_pkg::*;

  localparam int IDXW = $clog2(PALETTE_DEPTH);
  localparam int QW   = (IDXW + FRACTION_BITS > CHAN_W) ? IDXW + FRACTION_BITS : CHAN_W;
  localparam int NW   = ITER_W + QW;
  localparam int SW   = (SIZE_W > IDXW + 1) ? SIZE_W : IDXW + 1;
  localparam int AW   = (SLOT_W > IDXW + 1) ? SLOT_W : IDXW + 1;
  localparam int PMW  = ITER_W + IDXW;
  localparam int PW   = CHAN_W + FRACTION_BITS + 2;
  localparam int NST  = QW + 5;
  localparam int ST_M = QW + 2;
  localparam int ST_P = QW + 3;
  localparam int ST_O = QW + 4;

  // configuration
  logic [ITER_W-1:0] max_iter_q;
  logic [SIZE_W-1:0] pal_size_q;
  logic [ITER_W-1:0] max_eff;
  logic [SW-1:0]     size_ext;
  logic [SW-1:0]     size_eff;
  logic [SW-1:0]     last_full;
  logic [IDXW-1:0]   last;
  logic              pal_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
      pal_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_ITERATIONS: max_iter_q <= cfg_data_i;
        CFG_PALETTE_SIZE:   pal_size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    max_eff   = (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;
    size_ext  = SW'(pal_size_q);
    size_eff  = (size_ext > SW'(PALETTE_DEPTH)) ? SW'(PALETTE_DEPTH) : size_ext;
    pal_off   = (size_eff == '0);
    last_full = size_eff - SW'(1);
    last      = last_full[IDXW-1:0];
  end

  // stall handling: a stage takes a beat when empty or when it moves on
  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST-1:0] rdy;

  assign rdy[NST-1] = !vld_q[NST-1] || out_ready_i;
  for (genvar i = 0; i < NST - 1; i++) begin : g_rdy
    assign rdy[i] = !vld_q[i] || rdy[i+1];
  end
  assign in_ready_o = rdy[0];

  // stage A: saturate the count
  logic [ITER_W-1:0] it_sat;
  logic [ITER_W-1:0] a_it_d;
  tag_t              a_tag_d;
  logic [ITER_W-1:0] a_it_q;
  tag_t              a_tag_q;

  always_comb begin
    it_sat       = (iterations_i > max_eff) ? max_eff : iterations_i;
    a_it_d       = (!pal_off && it_sat == max_eff) ? '0 : it_sat;
    a_tag_d.op   = op_e'(operation_i);
    a_tag_d.grey = pal_off;
    a_tag_d.slot = entry_index_i;
    a_tag_d.rgb  = {entry_red_i, entry_green_i, entry_blue_i};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_it_q  <= a_it_d;
      a_tag_q <= a_tag_d;
    end
  end

  // stage B: form the dividend
  logic [ITER_W-1:0] dm;
  logic [PMW-1:0]    pm;
  logic [NW-1:0]     b_num_d;
  logic [NW-1:0]     b_num_q;
  tag_t              b_tag_q;

  always_comb begin
    dm = max_eff - a_it_q;
    pm = PMW'(a_it_q) * PMW'(last);
    // x * 255 as (x << 8) - x
    if (a_tag_q.grey) begin
      b_num_d = (NW'(dm) << CHAN_W) - NW'(dm);
    end else begin
      b_num_d = NW'(pm) << FRACTION_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      b_num_q <= b_num_d;
      b_tag_q <= a_tag_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [ITER_W-1:0] rem_src [QW];
  logic [QW-1:0]     qn_src  [QW];
  tag_t              tag_src [QW];
  logic [ITER_W-1:0] rem_q   [QW];
  logic [QW-1:0]     qn_q    [QW];
  tag_t              dt_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [ITER_W:0]   trial;
    logic [ITER_W:0]   diff;
    logic              ge;
    logic [ITER_W-1:0] rem_d;
    logic [QW-1:0]     qn_d;

    if (k == 0) begin : g_first
      assign rem_src[k] = b_num_q[NW-1:QW];
      assign qn_src[k]  = b_num_q[QW-1:0];
      assign tag_src[k] = b_tag_q;
    end else begin : g_next
      assign rem_src[k] = rem_q[k-1];
      assign qn_src[k]  = qn_q[k-1];
      assign tag_src[k] = dt_q[k-1];
    end

    always_comb begin
      trial = {rem_src[k], qn_src[k][QW-1]};
      diff  = trial - {1'b0, max_eff};
      ge    = (trial >= {1'b0, max_eff});
      rem_d = ge ? diff[ITER_W-1:0] : trial[ITER_W-1:0];
      qn_d  = {qn_src[k][QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+2]) begin
        rem_q[k] <= rem_d;
        qn_q[k]  <= qn_d;
        dt_q[k]  <= tag_src[k];
      end
    end
  end

  // stage M: palette access
  logic [QW-1:0]            quo;
  tag_t                     m_tag;
  logic [IDXW-1:0]          idx_raw;
  logic [IDXW-1:0]          idx;
  logic [IDXW:0]            up_inc;
  logic [IDXW-1:0]          up;
  logic [AW-1:0]            slot_ext;
  logic                     slot_ok;
  logic [IDXW-1:0]          waddr;
  logic                     load_en;
  logic [RGB_W-1:0]         pal_mem [PALETTE_DEPTH];
  logic [RGB_W-1:0]         m_lo_q;
  logic [RGB_W-1:0]         m_hi_q;
  logic [FRACTION_BITS-1:0] m_frac_q;
  logic                     m_grey_q;
  logic [CHAN_W-1:0]        m_gval_q;

  always_comb begin
    quo      = qn_q[QW-1];
    m_tag    = dt_q[QW-1];
    idx_raw  = quo[FRACTION_BITS +: IDXW];
    idx      = (idx_raw > last) ? last : idx_raw;
    up_inc   = {1'b0, idx} + (IDXW+1)'(1);
    up       = (up_inc > {1'b0, last}) ? last : up_inc[IDXW-1:0];
    slot_ext = AW'(m_tag.slot);
    slot_ok  = (slot_ext < AW'(PALETTE_DEPTH));
    waddr    = slot_ext[IDXW-1:0];
    load_en  = rdy[ST_M] && vld_q[ST_M-1] && (m_tag.op == OP_LOAD) && slot_ok;
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      pal_mem[waddr] <= m_tag.rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_M]) begin
      m_lo_q   <= pal_mem[idx];
      m_hi_q   <= pal_mem[up];
      m_frac_q <= quo[FRACTION_BITS-1:0];
      m_grey_q <= m_tag.grey;
      m_gval_q <= quo[CHAN_W-1:0];
    end
  end

  // stage P: lo*(1-f) + hi*f computed as lo + (hi-lo)*f
  logic signed [CHAN_W:0] chan_diff [3];
  logic signed [PW-1:0]   prod_d    [3];
  logic signed [PW-1:0]   p_prod_q  [3];
  logic [RGB_W-1:0]       p_lo_q;
  logic                   p_grey_q;
  logic [CHAN_W-1:0]      p_gval_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_diff[c] = $signed({1'b0, m_hi_q[c*CHAN_W +: CHAN_W]})
                   - $signed({1'b0, m_lo_q[c*CHAN_W +: CHAN_W]});
      prod_d[c]    = PW'(chan_diff[c]) * PW'($signed({1'b0, m_frac_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_P]) begin
      for (int c = 0; c < 3; c++) begin
        p_prod_q[c] <= prod_d[c];
      end
      p_lo_q   <= m_lo_q;
      p_grey_q <= m_grey_q;
      p_gval_q <= m_gval_q;
    end
  end

  // stage O: output register
  logic signed [PW-1:0] prod_sh [3];
  logic [RGB_W-1:0]     o_pix_d;
  logic [RGB_W-1:0]     o_pix_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_sh[c] = p_prod_q[c] >>> FRACTION_BITS;
      if (p_grey_q) begin
        o_pix_d[c*CHAN_W +: CHAN_W] = p_gval_q;
      end else begin
        o_pix_d[c*CHAN_W +: CHAN_W] = p_lo_q[c*CHAN_W +: CHAN_W] + prod_sh[c][CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_O]) begin
      o_pix_q <= o_pix_d;
    end
  end

  // valid bits; loads retire at the palette stage
  always_comb begin
    vld_d[0] = in_valid_i;
    for (int i = 1; i < NST; i++) begin
      vld_d[i] = vld_q[i-1];
    end
    vld_d[ST_M] = vld_q[ST_M-1] && (m_tag.op == OP_COLOR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  assign out_valid_o   = vld_q[ST_O];
  assign pixel_red_o   = o_pix_q[2*CHAN_W +: CHAN_W];
  assign pixel_green_o = o_pix_q[CHAN_W +: CHAN_W];
  assign pixel_blue_o  = o_pix_q[0 +: CHAN_W];

endmodule

[hdl/ipc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the iteration palette colorizer, bound to the top.
// ----------------------------------------------------------------------------
module ipc_checker #(
  parameter int PALETTE_DEPTH = ipc_pkg::IPC_PALETTE_DEPTH,
  parameter int FRACTION_BITS = ipc_pkg::IPC_FRACTION_BITS
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [ipc_pkg::ITER_W-1:0]     cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           operation_i,
  input logic [ipc_pkg::ITER_W-1:0]     iterations_i,
  input logic [ipc_pkg::SLOT_W-1:0]     entry_index_i,
  input logic [ipc_pkg::CHAN_W-1:0]     entry_red_i,
  input logic [ipc_pkg::CHAN_W-1:0]     entry_green_i,
  input logic [ipc_pkg::CHAN_W-1:0]     entry_blue_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ipc_pkg::CHAN_W-1:0]     pixel_red_o,
  input logic [ipc_pkg::CHAN_W-1:0]     pixel_green_o,
  input logic [ipc_pkg::CHAN_W-1:0]     pixel_blue_o
);
  import ipc_pkg::*;

  localparam int IDXW = $clog2(PALETTE_DEPTH);
  localparam int QW   = (IDXW + FRACTION_BITS > CHAN_W) ? IDXW + FRACTION_BITS : CHAN_W;
  localparam int NST  = QW + 5;
  localparam int CW   = $clog2(NST + 2);

  logic          color_beat;
  logic          out_beat;
  logic [CW-1:0] pending_d;
  logic [CW-1:0] pending_q;

  always_comb begin
    color_beat = in_valid_i && in_ready_o && (op_e'(operation_i) == OP_COLOR);
    out_beat   = out_valid_o && out_ready_i;
    pending_d  = pending_q + CW'(color_beat) - CW'(out_beat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_pixel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_red_o)
      && $stable(pixel_green_o) && $stable(pixel_blue_o))
    else $error("pixel beat changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although the output stage moves");

  a_pixel_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("pixel beat without an outstanding colour item");

  a_pipe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CW'(NST))
    else $error("more colour items in flight than pipeline stages");

endmodule

bind iteration_palette_colorizer ipc_checker #(
  .PALETTE_DEPTH(PALETTE_DEPTH),
  .FRACTION_BITS(FRACTION_BITS)
) u_ipc_checker (.*);
